### hdl/map_correlation_and_residual_assert.svh
// Assertion macros for the correlation and residual block.
// Used by the port checker; no other dependencies.
`ifndef MAP_CORRELATION_AND_RESIDUAL_ASSERT_SVH
`define MAP_CORRELATION_AND_RESIDUAL_ASSERT_SVH

// Same-cycle implication under reset.
`define MCR_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mcr check failed: same-cycle rule");

// Next-cycle implication under reset.
`define MCR_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mcr check failed: next-cycle rule");

`endif

### hdl/mcr_pkg.sv
// Shared widths, types and helpers for the correlation and residual block.
// No dependencies.
package mcr_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int SAMPLE_BITS = 16;

    localparam int IN_W     = 16;
    localparam int CORR_W   = 16;
    localparam int RATIO_W  = 24;
    localparam int STATUS_W = 2;
    localparam int PAIRS_W  = 25;

    localparam int CORR_FRAC  = CORR_W - 1;
    localparam int RATIO_FRAC = 16;

    localparam int N_W   = COUNT_BITS + 1;
    localparam int SUM_W = COUNT_BITS + SAMPLE_BITS;
    localparam int SQ_W  = COUNT_BITS + 2 * SAMPLE_BITS - 1;
    localparam int XP_W  = COUNT_BITS + 2 * SAMPLE_BITS;
    localparam int DT_W  = XP_W + 2;
    localparam int V_W   = 2 * COUNT_BITS + 2 * SAMPLE_BITS;
    localparam int CV_W  = V_W + 2;
    localparam int P_W   = 2 * V_W;
    localparam int CSH   = 2 * (CORR_FRAC + 1);
    localparam int D_W   = P_W + CSH;

    localparam int CQ_STEPS  = CSH + 1;
    localparam int RAT_STEPS = RATIO_W + 1;
    localparam int RSH       = RATIO_FRAC + 1;
    localparam int SQRT_BITS = CORR_FRAC + 2;

    localparam int MCNT_W = $clog2(V_W);
    localparam int DCNT_W = $clog2(CQ_STEPS);
    localparam int SCNT_W = $clog2(SQRT_BITS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FLAT   = 2'd1,
        STATUS_NO_RES = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_M_NSXX,
        ST_M_SX2,
        ST_M_NSYY,
        ST_M_SY2,
        ST_M_NSXY,
        ST_M_SXSY,
        ST_M_VV,
        ST_M_CC,
        ST_D_CORR,
        ST_SQRT,
        ST_D_RAT,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [N_W-1:0]         n;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic [SQ_W-1:0]        sxx;
        logic [SQ_W-1:0]        syy;
        logic signed [XP_W-1:0] sxy;
    } sums_t;

    function automatic logic [XP_W-1:0] mag_xp(input logic signed [XP_W-1:0] v);
        logic [XP_W-1:0] neg;
        neg = XP_W'(-v);
        return v[XP_W-1] ? neg : XP_W'(v);
    endfunction

    function automatic logic signed [XP_W-1:0] ext_sum(input logic signed [SUM_W-1:0] v);
        return {{(XP_W - SUM_W){v[SUM_W-1]}}, v};
    endfunction

endpackage

### hdl/mcr_in_if.sv
// Sample pair channel: valid/ready handshake with paired samples and last flag.
// Depends on mcr_pkg.
interface mcr_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [mcr_pkg::IN_W-1:0]    x_sample;
    logic signed [mcr_pkg::IN_W-1:0]    y_sample;
    logic                               last;

    modport source (output valid, output x_sample, output y_sample, output last,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input last,
                    output ready);
endinterface

### hdl/mcr_out_if.sv
// Result channel: valid/ready handshake with correlation, ratio, status, count.
// Depends on mcr_pkg.
interface mcr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mcr_pkg::CORR_W-1:0]  correlation;
    logic [mcr_pkg::RATIO_W-1:0]        residual_ratio;
    mcr_pkg::status_t                   status;
    logic [mcr_pkg::PAIRS_W-1:0]        pair_count;

    modport source (output valid, output correlation, output residual_ratio,
                    output status, output pair_count, input ready);
    modport sink   (input valid, input correlation, input residual_ratio,
                    input status, input pair_count, output ready);
endinterface

### hdl/mcr_front.sv
// Front end: accepts sample pairs, accumulates count and sums, hands off on last.
// Depends on mcr_pkg and mcr_in_if.
module mcr_front (
    input  logic            clk,
    input  logic            rst_n,
    mcr_in_if.sink          samples,
    output logic            push_valid,
    input  logic            push_ready,
    output mcr_pkg::sums_t  push_sums
);

    logic [mcr_pkg::N_W-1:0]            n_reg;
    logic signed [mcr_pkg::SUM_W-1:0]   sx_reg;
    logic signed [mcr_pkg::SUM_W-1:0]   sy_reg;
    logic [mcr_pkg::SQ_W-1:0]           sxx_reg;
    logic [mcr_pkg::SQ_W-1:0]           syy_reg;
    logic signed [mcr_pkg::XP_W-1:0]    sxy_reg;

    logic signed [mcr_pkg::SAMPLE_BITS-1:0]     xs;
    logic signed [mcr_pkg::SAMPLE_BITS-1:0]     ys;
    logic signed [2*mcr_pkg::SAMPLE_BITS-1:0]   x_sq;
    logic signed [2*mcr_pkg::SAMPLE_BITS-1:0]   y_sq;
    logic signed [2*mcr_pkg::SAMPLE_BITS-1:0]   xy;
    logic                                       accept;
    logic                                       room;
    mcr_pkg::sums_t                             acc_next;

    assign xs     = samples.x_sample[mcr_pkg::SAMPLE_BITS-1:0];
    assign ys     = samples.y_sample[mcr_pkg::SAMPLE_BITS-1:0];
    assign x_sq   = xs * xs;
    assign y_sq   = ys * ys;
    assign xy     = xs * ys;
    assign accept = samples.valid && samples.ready;
    assign room   = !n_reg[mcr_pkg::COUNT_BITS];

    assign samples.ready = push_ready;

    always_comb
    begin
        acc_next.n   = n_reg;
        acc_next.sx  = sx_reg;
        acc_next.sy  = sy_reg;
        acc_next.sxx = sxx_reg;
        acc_next.syy = syy_reg;
        acc_next.sxy = sxy_reg;
        if (room)
        begin
            acc_next.n   = n_reg + 1'b1;
            acc_next.sx  = sx_reg + {{(mcr_pkg::SUM_W - mcr_pkg::SAMPLE_BITS){xs[mcr_pkg::SAMPLE_BITS-1]}}, xs};
            acc_next.sy  = sy_reg + {{(mcr_pkg::SUM_W - mcr_pkg::SAMPLE_BITS){ys[mcr_pkg::SAMPLE_BITS-1]}}, ys};
            acc_next.sxx = sxx_reg + mcr_pkg::SQ_W'($unsigned(x_sq));
            acc_next.syy = syy_reg + mcr_pkg::SQ_W'($unsigned(y_sq));
            acc_next.sxy = sxy_reg
                + {{(mcr_pkg::XP_W - 2*mcr_pkg::SAMPLE_BITS){xy[2*mcr_pkg::SAMPLE_BITS-1]}}, xy};
        end
    end

    assign push_valid = accept && samples.last;
    assign push_sums  = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else if (accept)
        begin
            if (samples.last)
            begin
                n_reg   <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
                sxy_reg <= '0;
            end
            else
            begin
                n_reg   <= acc_next.n;
                sx_reg  <= acc_next.sx;
                sy_reg  <= acc_next.sy;
                sxx_reg <= acc_next.sxx;
                syy_reg <= acc_next.syy;
                sxy_reg <= acc_next.sxy;
            end
        end
    end

endmodule

### hdl/mcr_queue.sv
// Two-entry queue of finished sum sets between front and back end.
// Depends on mcr_pkg.
module mcr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mcr_pkg::sums_t  push_sums,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mcr_pkg::sums_t  pop_sums
);

    mcr_pkg::sums_t                 entry_reg [mcr_pkg::QUEUE_DEPTH];
    logic [mcr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [mcr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [mcr_pkg::QCNT_W-1:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = count_reg != mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_sums   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_sums;
    end

endmodule

### hdl/mcr_back.sv
// Back end: shift-add multiplier, restoring divider and bitwise root sequenced
// to form correlation and residual ratio. Depends on mcr_pkg and mcr_out_if.
module mcr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  mcr_pkg::sums_t  pop_sums,
    mcr_out_if.source       results
);

    mcr_pkg::back_state_t state_reg, state_next;

    mcr_pkg::sums_t                     snap_reg;
    logic [mcr_pkg::P_W-1:0]            mul_a_reg;
    logic [mcr_pkg::V_W-1:0]            mul_b_reg;
    logic [mcr_pkg::P_W-1:0]            mul_acc_reg;
    logic [mcr_pkg::MCNT_W-1:0]         mcnt_reg;
    logic [mcr_pkg::P_W-1:0]            tmp_reg;
    logic [mcr_pkg::V_W-1:0]            vx_reg;
    logic [mcr_pkg::V_W-1:0]            vy_reg;
    logic [mcr_pkg::V_W-1:0]            cov_reg;
    logic                               cov_neg_reg;
    logic [mcr_pkg::D_W-1:0]            rem_reg;
    logic [mcr_pkg::D_W-1:0]            dsr_reg;
    logic [mcr_pkg::CQ_STEPS-1:0]       quo_reg;
    logic [mcr_pkg::DCNT_W-1:0]         dcnt_reg;
    logic [mcr_pkg::SQRT_BITS-1:0]      root_reg;
    logic [mcr_pkg::SCNT_W-1:0]         scnt_reg;
    logic signed [mcr_pkg::CORR_W-1:0]  corr_reg;
    logic [mcr_pkg::RATIO_W-1:0]        ratio_reg;
    mcr_pkg::status_t                   status_reg;

    logic [mcr_pkg::P_W-1:0]            mul_sum;
    logic                               mul_last;
    logic [mcr_pkg::V_W-1:0]            vy_now;
    logic                               flat;
    logic signed [mcr_pkg::CV_W-1:0]    s1;
    logic signed [mcr_pkg::CV_W-1:0]    s2;
    logic signed [mcr_pkg::CV_W-1:0]    cov_s;
    logic [mcr_pkg::CV_W-1:0]           cov_abs;
    logic                               ge;
    logic [mcr_pkg::CQ_STEPS-1:0]       quo_next;
    logic                               div_last;
    logic [mcr_pkg::SCNT_W-1:0]         bit_sh;
    logic [mcr_pkg::SQRT_BITS-1:0]      trial;
    logic [2*mcr_pkg::SQRT_BITS-1:0]    trial_sq;
    logic [mcr_pkg::SQRT_BITS-1:0]      root_new;
    logic [mcr_pkg::SQRT_BITS:0]        root_inc;
    logic [mcr_pkg::SQRT_BITS-1:0]      m_val;
    logic signed [mcr_pkg::SQRT_BITS-1:0] m_neg;
    logic                               sqrt_last;
    logic signed [mcr_pkg::DT_W-1:0]    sq_sum;
    logic signed [mcr_pkg::DT_W-1:0]    twos;
    logic signed [mcr_pkg::DT_W-1:0]    d_val;
    logic signed [mcr_pkg::DT_W-1:0]    t_val;
    logic                               t_zero;
    mcr_pkg::back_state_t               rat_next;
    logic [mcr_pkg::XP_W-1:0]           ax;
    logic [mcr_pkg::XP_W-1:0]           ay;
    logic [mcr_pkg::XP_W-1:0]           axy;

    // Shared datapath terms
    assign mul_sum  = mul_acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);
    assign mul_last = mcnt_reg == mcr_pkg::MCNT_W'(mcr_pkg::V_W - 1);
    assign vy_now   = mcr_pkg::V_W'(tmp_reg - mul_sum);
    assign flat     = (vx_reg == '0) || (vy_now == '0);

    assign ax  = mcr_pkg::mag_xp(mcr_pkg::ext_sum(snap_reg.sx));
    assign ay  = mcr_pkg::mag_xp(mcr_pkg::ext_sum(snap_reg.sy));
    assign axy = mcr_pkg::mag_xp(snap_reg.sxy);

    always_comb
    begin
        s1 = signed'({2'b00, tmp_reg[mcr_pkg::V_W-1:0]});
        s2 = signed'({2'b00, mul_sum[mcr_pkg::V_W-1:0]});
        if (snap_reg.sxy[mcr_pkg::XP_W-1])
            s1 = -s1;
        if (snap_reg.sx[mcr_pkg::SUM_W-1] != snap_reg.sy[mcr_pkg::SUM_W-1])
            s2 = -s2;
        cov_s   = s1 - s2;
        cov_abs = cov_s[mcr_pkg::CV_W-1] ? mcr_pkg::CV_W'(-cov_s) : mcr_pkg::CV_W'(cov_s);
    end

    assign ge       = rem_reg >= dsr_reg;
    assign quo_next = {quo_reg[mcr_pkg::CQ_STEPS-2:0], ge};
    assign div_last = (state_reg == mcr_pkg::ST_D_CORR)
                    ? (dcnt_reg == mcr_pkg::DCNT_W'(mcr_pkg::CQ_STEPS - 1))
                    : (dcnt_reg == mcr_pkg::DCNT_W'(mcr_pkg::RAT_STEPS - 1));

    assign bit_sh    = mcr_pkg::SCNT_W'(mcr_pkg::SQRT_BITS - 1) - scnt_reg;
    assign trial     = root_reg | (mcr_pkg::SQRT_BITS'(1) << bit_sh);
    assign trial_sq  = trial * trial;
    assign root_new  = (trial_sq <= (2*mcr_pkg::SQRT_BITS)'(quo_reg)) ? trial : root_reg;
    assign root_inc  = {1'b0, root_new} + 1'b1;
    assign m_val     = root_inc[mcr_pkg::SQRT_BITS:1];
    assign m_neg     = -signed'(m_val);
    assign sqrt_last = scnt_reg == mcr_pkg::SCNT_W'(mcr_pkg::SQRT_BITS - 1);

    assign sq_sum = signed'(mcr_pkg::DT_W'(snap_reg.sxx)) + signed'(mcr_pkg::DT_W'(snap_reg.syy));
    assign twos   = signed'({{(mcr_pkg::DT_W - mcr_pkg::XP_W){snap_reg.sxy[mcr_pkg::XP_W-1]}},
                             snap_reg.sxy}) <<< 1;
    assign d_val  = sq_sum - twos;
    assign t_val  = sq_sum + twos;
    assign t_zero = t_val == '0;
    assign rat_next = t_zero ? mcr_pkg::ST_DONE : mcr_pkg::ST_D_RAT;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcr_pkg::ST_IDLE:   if (pop_valid) state_next = mcr_pkg::ST_LOAD;
            mcr_pkg::ST_LOAD:   state_next = mcr_pkg::ST_M_NSXX;
            mcr_pkg::ST_M_NSXX: if (mul_last) state_next = mcr_pkg::ST_M_SX2;
            mcr_pkg::ST_M_SX2:  if (mul_last) state_next = mcr_pkg::ST_M_NSYY;
            mcr_pkg::ST_M_NSYY: if (mul_last) state_next = mcr_pkg::ST_M_SY2;
            mcr_pkg::ST_M_SY2:  if (mul_last) state_next = flat ? rat_next : mcr_pkg::ST_M_NSXY;
            mcr_pkg::ST_M_NSXY: if (mul_last) state_next = mcr_pkg::ST_M_SXSY;
            mcr_pkg::ST_M_SXSY: if (mul_last) state_next = mcr_pkg::ST_M_VV;
            mcr_pkg::ST_M_VV:   if (mul_last) state_next = mcr_pkg::ST_M_CC;
            mcr_pkg::ST_M_CC:   if (mul_last) state_next = mcr_pkg::ST_D_CORR;
            mcr_pkg::ST_D_CORR: if (div_last) state_next = mcr_pkg::ST_SQRT;
            mcr_pkg::ST_SQRT:   if (sqrt_last) state_next = rat_next;
            mcr_pkg::ST_D_RAT:  if (div_last) state_next = mcr_pkg::ST_DONE;
            mcr_pkg::ST_DONE:   if (results.ready) state_next = mcr_pkg::ST_IDLE;
            default:            state_next = mcr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop_ready     = 1'b0;
        results.valid = 1'b0;
        unique case (state_reg)
            mcr_pkg::ST_IDLE: pop_ready = 1'b1;
            mcr_pkg::ST_DONE: results.valid = 1'b1;
            default:
            begin
                pop_ready     = 1'b0;
                results.valid = 1'b0;
            end
        endcase
    end

    assign results.correlation    = corr_reg;
    assign results.residual_ratio = ratio_reg;
    assign results.status         = status_reg;
    assign results.pair_count     = mcr_pkg::PAIRS_W'(snap_reg.n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mcr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        // advance the active unit
        case (state_reg)
            mcr_pkg::ST_M_NSXX, mcr_pkg::ST_M_SX2, mcr_pkg::ST_M_NSYY, mcr_pkg::ST_M_SY2,
            mcr_pkg::ST_M_NSXY, mcr_pkg::ST_M_SXSY, mcr_pkg::ST_M_VV, mcr_pkg::ST_M_CC:
            begin
                mul_acc_reg <= mul_sum;
                mul_a_reg   <= mul_a_reg << 1;
                mul_b_reg   <= mul_b_reg >> 1;
                mcnt_reg    <= mcnt_reg + 1'b1;
            end
            mcr_pkg::ST_D_CORR, mcr_pkg::ST_D_RAT:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsr_reg;
                dsr_reg  <= dsr_reg >> 1;
                quo_reg  <= quo_next;
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            mcr_pkg::ST_SQRT:
            begin
                root_reg <= root_new;
                scnt_reg <= scnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        // capture finished results
        case (state_reg)
            mcr_pkg::ST_IDLE:
                if (pop_valid)
                    snap_reg <= pop_sums;
            mcr_pkg::ST_LOAD:
            begin
                status_reg <= mcr_pkg::STATUS_OK;
                corr_reg   <= '0;
            end
            mcr_pkg::ST_M_NSXX, mcr_pkg::ST_M_NSYY, mcr_pkg::ST_M_NSXY, mcr_pkg::ST_M_VV:
                if (mul_last)
                    tmp_reg <= mul_sum;
            mcr_pkg::ST_M_SX2:
                if (mul_last)
                    vx_reg <= mcr_pkg::V_W'(tmp_reg - mul_sum);
            mcr_pkg::ST_M_SY2:
                if (mul_last)
                begin
                    vy_reg <= vy_now;
                    if (flat)
                        status_reg <= mcr_pkg::STATUS_FLAT;
                end
            mcr_pkg::ST_M_SXSY:
                if (mul_last)
                begin
                    cov_reg     <= mcr_pkg::V_W'(cov_abs);
                    cov_neg_reg <= cov_s[mcr_pkg::CV_W-1];
                end
            mcr_pkg::ST_SQRT:
                if (sqrt_last)
                begin
                    if (cov_neg_reg)
                        corr_reg <= mcr_pkg::CORR_W'(m_neg);
                    else if (m_val > mcr_pkg::SQRT_BITS'({1'b0, {mcr_pkg::CORR_FRAC{1'b1}}}))
                        corr_reg <= {1'b0, {mcr_pkg::CORR_FRAC{1'b1}}};
                    else
                        corr_reg <= mcr_pkg::CORR_W'(m_val);
                end
            default:
            begin
            end
        endcase

        // load operands on entry to a step
        if (state_next != state_reg)
        begin
            case (state_next)
                mcr_pkg::ST_M_NSXX:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(snap_reg.n);
                    mul_b_reg <= mcr_pkg::V_W'(snap_reg.sxx);
                end
                mcr_pkg::ST_M_SX2:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(ax);
                    mul_b_reg <= mcr_pkg::V_W'(ax);
                end
                mcr_pkg::ST_M_NSYY:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(snap_reg.n);
                    mul_b_reg <= mcr_pkg::V_W'(snap_reg.syy);
                end
                mcr_pkg::ST_M_SY2:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(ay);
                    mul_b_reg <= mcr_pkg::V_W'(ay);
                end
                mcr_pkg::ST_M_NSXY:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(snap_reg.n);
                    mul_b_reg <= mcr_pkg::V_W'(axy);
                end
                mcr_pkg::ST_M_SXSY:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(ax);
                    mul_b_reg <= mcr_pkg::V_W'(ay);
                end
                mcr_pkg::ST_M_VV:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(vx_reg);
                    mul_b_reg <= vy_reg;
                end
                mcr_pkg::ST_M_CC:
                begin
                    mul_a_reg <= mcr_pkg::P_W'(cov_reg);
                    mul_b_reg <= cov_reg;
                end
                mcr_pkg::ST_D_CORR:
                begin
                    rem_reg  <= mcr_pkg::D_W'(mul_sum) << mcr_pkg::CSH;
                    dsr_reg  <= mcr_pkg::D_W'(tmp_reg) << mcr_pkg::CSH;
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                end
                mcr_pkg::ST_SQRT:
                begin
                    root_reg <= '0;
                    scnt_reg <= '0;
                end
                mcr_pkg::ST_D_RAT:
                begin
                    rem_reg  <= (mcr_pkg::D_W'($unsigned(d_val)) << mcr_pkg::RSH)
                              + mcr_pkg::D_W'($unsigned(t_val));
                    dsr_reg  <= mcr_pkg::D_W'($unsigned(t_val)) << mcr_pkg::RAT_STEPS;
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                end
                mcr_pkg::ST_DONE:
                begin
                    if (state_reg == mcr_pkg::ST_D_RAT)
                    begin
                        if (quo_next[mcr_pkg::RATIO_W])
                            ratio_reg <= '1;
                        else
                            ratio_reg <= quo_next[mcr_pkg::RATIO_W-1:0];
                    end
                    else
                    begin
                        ratio_reg <= '0;
                        if (state_reg == mcr_pkg::ST_SQRT || !flat)
                            status_reg <= mcr_pkg::STATUS_NO_RES;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (state_next != state_reg)
        begin
            mcnt_reg    <= '0;
            mul_acc_reg <= '0;
        end
    end

endmodule

### hdl/map_correlation_and_residual.sv
// Pearson correlation and residual ratio of two maps. Accepts one sample pair per
// cycle while the result queue has room; a last pair hands its sums to the back end.
// Result sequence after the last pair: eight shift-add multiplies, a correlation divide,
// a bitwise root and a ratio divide; shorter on zero variance.
// Two finished maps may queue behind the back end. Async active-low reset clears
// the accumulators, the queue and the sequencer.
module map_correlation_and_residual (
    input  logic        clk,
    input  logic        rst_n,
    mcr_in_if.sink      samples,
    mcr_out_if.source   results
);

    logic            push_valid;
    logic            push_ready;
    mcr_pkg::sums_t  push_sums;
    logic            pop_valid;
    logic            pop_ready;
    mcr_pkg::sums_t  pop_sums;

    mcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sums  (push_sums)
    );

    mcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sums  (push_sums),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_sums   (pop_sums)
    );

    mcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_sums   (pop_sums),
        .results    (results)
    );

endmodule

### hdl/mcr_checker.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on mcr_pkg and map_correlation_and_residual_assert.svh.
`include "map_correlation_and_residual_assert.svh"

module mcr_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [mcr_pkg::CORR_W-1:0]  correlation,
    input  logic [mcr_pkg::RATIO_W-1:0]        residual_ratio,
    input  logic [mcr_pkg::STATUS_W-1:0]       status,
    input  logic [mcr_pkg::PAIRS_W-1:0]        pair_count
);

    `MCR_ASSERT_NOW(flat_has_zero_corr, clk, rst_n,
        out_valid && status == mcr_pkg::STATUS_FLAT, correlation == '0)

    `MCR_ASSERT_NOW(no_res_has_zero_ratio, clk, rst_n,
        out_valid && status == mcr_pkg::STATUS_NO_RES, residual_ratio == '0)

    `MCR_ASSERT_NOW(result_has_pairs, clk, rst_n, out_valid, pair_count != '0)

    `MCR_ASSERT_NEXT(result_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(correlation) && $stable(residual_ratio)
        && $stable(status) && $stable(pair_count))

endmodule

bind map_correlation_and_residual mcr_checker u_mcr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .correlation    (results.correlation),
    .residual_ratio (results.residual_ratio),
    .status         (results.status),
    .pair_count     (results.pair_count)
);
